>>> rtl/core/ialu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Integer ALU package
// Shared types, operation codes, datapath commands and constants.
// ----------------------------------------------------------------------------
package ialu_pkg;

  localparam int DATA_WIDTH_DEFAULT = 32;
  localparam int FIELD_WIDTH        = 32;
  localparam int ACTION_WIDTH       = 4;
  localparam int RADIX_MIN          = 2;

  typedef logic [ACTION_WIDTH-1:0]       action_t;
  typedef logic signed [FIELD_WIDTH-1:0] field_t;

  typedef enum logic [ACTION_WIDTH-1:0] {
    ACT_ADD     = 4'd0,
    ACT_SUB     = 4'd1,
    ACT_MUL     = 4'd2,
    ACT_DIV     = 4'd3,
    ACT_REM     = 4'd4,
    ACT_OR      = 4'd5,
    ACT_XOR     = 4'd6,
    ACT_AND     = 4'd7,
    ACT_CONV    = 4'd8,
    ACT_INVALID = 4'd9
  } action_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_MUL_INIT,
    CMD_MUL_STEP,
    CMD_CONV_ACC,
    CMD_RES
  } dp_cmd_e;

  typedef struct packed {
    action_e op;
    logic    bad;
    logic    div_done;
    logic    mul_done;
    logic    val_zero;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/ialu_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying the operation code and both operands.
// ----------------------------------------------------------------------------
interface ialu_req_if import ialu_pkg::*; ();
  logic    valid;
  logic    ready;
  action_t action;
  field_t  operand_a;
  field_t  operand_b;

  modport source (output valid, output action, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input action, input operand_a, input operand_b,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/core/ialu_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the result and the invalid flag.
// ----------------------------------------------------------------------------
interface ialu_rsp_if import ialu_pkg::*; ();
  logic   valid;
  logic   ready;
  field_t result;
  logic   invalid;

  modport source (output valid, output result, output invalid, input ready);
  modport sink   (input valid, input result, input invalid, output ready);
endinterface
`default_nettype wire

>>> rtl/core/ialu_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Integer ALU controller
// Sequences the datapath through divide, multiply and conversion loops and
// owns the handshakes, the output valid flag and the sticky halt flag.
// ----------------------------------------------------------------------------
module ialu_ctrl import ialu_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    req_valid_i,
  input  wire logic    rsp_ready_i,
  input  wire dp_sts_t sts_i,
  output logic         req_ready_o,
  output logic         rsp_valid_o,
  output dp_cmd_e      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_DIV,
    ST_CONV,
    ST_ACC,
    ST_FINISH
  } state_e;

  state_e  state_q, state_d;
  logic    rsp_valid_q;
  logic    halted_q;
  dp_cmd_e cmd;
  logic    is_conv;

  assign is_conv = (sts_i.op == ACT_CONV);

  always_comb begin
    cmd     = CMD_NONE;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i && !halted_q) begin
          cmd     = CMD_LOAD;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.bad) begin
          state_d = ST_FINISH;
        end else begin
          unique case (sts_i.op)
            ACT_MUL: begin
              cmd     = CMD_MUL_INIT;
              state_d = ST_MUL;
            end
            ACT_DIV, ACT_REM: begin
              cmd     = CMD_DIV_INIT;
              state_d = ST_DIV;
            end
            ACT_CONV: state_d = ST_CONV;
            default:  state_d = ST_FINISH;
          endcase
        end
      end
      ST_MUL: begin
        if (sts_i.mul_done) begin
          state_d = is_conv ? ST_ACC : ST_FINISH;
        end else begin
          cmd = CMD_MUL_STEP;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          if (is_conv) begin
            cmd     = CMD_MUL_INIT;
            state_d = ST_MUL;
          end else begin
            state_d = ST_FINISH;
          end
        end else begin
          cmd = CMD_DIV_STEP;
        end
      end
      ST_CONV: begin
        if (sts_i.val_zero) begin
          state_d = ST_FINISH;
        end else begin
          cmd     = CMD_DIV_INIT;
          state_d = ST_DIV;
        end
      end
      ST_ACC: begin
        cmd     = CMD_CONV_ACC;
        state_d = ST_CONV;
      end
      ST_FINISH: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd     = CMD_RES;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
      halted_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd == CMD_RES) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      if (cmd == CMD_RES && sts_i.bad) begin
        halted_q <= 1'b1;
      end
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign cmd_o       = cmd;

endmodule
`default_nettype wire

>>> rtl/core/ialu_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Integer ALU datapath
// Operand registers, a radix-2 restoring divider, a shift-add multiplier,
// the conversion accumulator and the result register.
// ----------------------------------------------------------------------------
module ialu_dp import ialu_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  wire logic    clk_i,
  input  wire dp_cmd_e cmd_i,
  input  wire action_t action_i,
  input  wire field_t  operand_a_i,
  input  wire field_t  operand_b_i,
  output dp_sts_t      sts_o,
  output field_t       result_o,
  output logic         invalid_o
);

  localparam int CntW = $clog2(DATA_WIDTH + 1);

  typedef logic [DATA_WIDTH-1:0] word_t;

  action_e         op_q;
  word_t           a_q, b_q, val_q, acc_q, weight_q;
  word_t           rem_q, quo_q, dvs_q;
  word_t           mcand_q, mplier_q, prod_q;
  word_t           res_q;
  logic            inv_q;
  logic [CntW-1:0] cnt_q;

  logic            sign_v, sign_b;
  word_t           mag_v, mag_b;
  logic [DATA_WIDTH:0] trial, diff;
  word_t           s_quo, s_rem, s_prod;
  word_t           alu_res;
  logic            bad;

  assign sign_v = val_q[DATA_WIDTH-1];
  assign sign_b = b_q[DATA_WIDTH-1];
  assign mag_v  = sign_v ? -val_q : val_q;
  assign mag_b  = sign_b ? -b_q : b_q;

  assign trial  = {rem_q, quo_q[DATA_WIDTH-1]};
  assign diff   = trial - {1'b0, dvs_q};

  assign s_quo  = (sign_v ^ sign_b) ? -quo_q : quo_q;
  assign s_rem  = sign_v ? -rem_q : rem_q;
  assign s_prod = sign_v ? -prod_q : prod_q;

  always_comb begin
    unique case (op_q)
      ACT_DIV, ACT_REM: bad = (b_q == '0);
      ACT_CONV:         bad = ($signed(b_q) < $signed(DATA_WIDTH'(RADIX_MIN)));
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_OR, ACT_XOR, ACT_AND: bad = 1'b0;
      default:          bad = 1'b1;
    endcase
  end

  always_comb begin
    unique case (op_q)
      ACT_ADD:  alu_res = a_q + b_q;
      ACT_SUB:  alu_res = a_q - b_q;
      ACT_MUL:  alu_res = prod_q;
      ACT_DIV:  alu_res = s_quo;
      ACT_REM:  alu_res = s_rem;
      ACT_OR:   alu_res = a_q | b_q;
      ACT_XOR:  alu_res = a_q ^ b_q;
      ACT_AND:  alu_res = a_q & b_q;
      ACT_CONV: alu_res = acc_q;
      default:  alu_res = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD: begin
        op_q     <= action_e'(action_i);
        a_q      <= DATA_WIDTH'(operand_a_i);
        b_q      <= DATA_WIDTH'(operand_b_i);
        val_q    <= DATA_WIDTH'(operand_a_i);
        acc_q    <= '0;
        weight_q <= word_t'(1);
      end
      CMD_DIV_INIT: begin
        quo_q <= mag_v;
        dvs_q <= mag_b;
        rem_q <= '0;
        cnt_q <= CntW'(DATA_WIDTH);
      end
      CMD_DIV_STEP: begin
        if (!diff[DATA_WIDTH]) begin
          rem_q <= diff[DATA_WIDTH-1:0];
        end else begin
          rem_q <= trial[DATA_WIDTH-1:0];
        end
        quo_q <= {quo_q[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
        cnt_q <= cnt_q - 1'b1;
      end
      CMD_MUL_INIT: begin
        prod_q <= '0;
        if (op_q == ACT_CONV) begin
          mcand_q  <= weight_q;
          mplier_q <= rem_q;
        end else begin
          mcand_q  <= b_q;
          mplier_q <= a_q;
        end
      end
      CMD_MUL_STEP: begin
        if (mplier_q[0]) begin
          prod_q <= prod_q + mcand_q;
        end
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
      end
      CMD_CONV_ACC: begin
        acc_q    <= acc_q + s_prod;
        val_q    <= s_quo;
        weight_q <= (weight_q << 3) + (weight_q << 1);
      end
      CMD_RES: begin
        res_q <= bad ? '0 : alu_res;
        inv_q <= bad;
      end
      default: begin
      end
    endcase
  end

  assign sts_o.op       = op_q;
  assign sts_o.bad      = bad;
  assign sts_o.div_done = (cnt_q == '0);
  assign sts_o.mul_done = (mplier_q == '0);
  assign sts_o.val_zero = (val_q == '0);

  assign result_o  = FIELD_WIDTH'($signed(res_q));
  assign invalid_o = inv_q;

endmodule
`default_nettype wire

>>> rtl/core/integer_alu_with_base_conversion_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Integer ALU with base conversion
// Add, subtract, multiply, divide, remainder, logic operations and radix
// conversion, with a sticky halt after a rejected operation.
// ----------------------------------------------------------------------------
// Add, subtract and logic operations pass through the decode and finish
// states only; multiply steps the shift-add multiplier once per significant
// bit of operand A, and divide and remainder step the one-bit-per-cycle
// divider DATA_WIDTH times. Conversion runs a divide, a multiply and an
// accumulate per output digit. One item is in work at a time. Reset clears
// the halt flag and the output valid flag; no clearing pass is needed.
module integer_alu_with_base_conversion_core import ialu_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ialu_req_if.sink   req_i,
  ialu_rsp_if.source rsp_o
);

  dp_cmd_e cmd;
  dp_sts_t sts;

  ialu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .cmd_o       (cmd)
  );

  ialu_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .action_i    (req_i.action),
    .operand_a_i (req_i.operand_a),
    .operand_b_i (req_i.operand_b),
    .sts_o       (sts),
    .result_o    (rsp_o.result),
    .invalid_o   (rsp_o.invalid)
  );

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Integer ALU testbench
// Drives a table of directed operations and then random operations in three
// idling phases, predicts every result in the bench and compares each result
// transfer field by field. The run ends with one rejected operation and a few
// items that the halted block must swallow without a result.
// ----------------------------------------------------------------------------
module tb_top import ialu_pkg::*; ();

  localparam field_t MIN_VAL        = 32'sh8000_0000;
  localparam field_t MAX_VAL        = 32'sh7fff_ffff;
  localparam int     RANDOM_PER_PH  = 180;
  localparam int     HOLD_CYCLES    = 400;
  localparam int     TAIL_CYCLES    = 1500;
  localparam int     WATCHDOG_LIMIT = 20000;

  typedef struct {
    field_t result;
    logic   invalid;
  } alu_result_t;

  typedef struct {
    action_t act;
    field_t  a;
    field_t  b;
    bit      typed;
    field_t  result;
  } stim_row_t;

  typedef enum int {
    REJ_DIV_ZERO,
    REJ_REM_ZERO,
    REJ_LOW_RADIX,
    REJ_INVALID,
    REJ_UNUSED
  } reject_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  ialu_req_if req_if ();
  ialu_rsp_if rsp_if ();

  integer_alu_with_base_conversion_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  alu_result_t owed_results[$];
  bit          alu_halted    = 1'b0;
  int          mismatches    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  int          idle_cycles   = 0;

  logic        row_typed;
  field_t      row_result;
  logic        row_invalid;

  stim_row_t directed_rows[24] = '{
    '{ACT_ADD,  MAX_VAL,       32'sd1,        1'b1, MIN_VAL},
    '{ACT_ADD,  MIN_VAL,       MIN_VAL,       1'b1, 32'sd0},
    '{ACT_SUB,  MIN_VAL,       32'sd1,        1'b1, MAX_VAL},
    '{ACT_SUB,  32'sd0,        MIN_VAL,       1'b1, MIN_VAL},
    '{ACT_MUL,  MIN_VAL,       -32'sd1,       1'b1, MIN_VAL},
    '{ACT_MUL,  MAX_VAL,       MAX_VAL,       1'b1, 32'sd1},
    '{ACT_MUL,  32'sd12345,    -32'sd678,     1'b0, 32'sd0},
    '{ACT_DIV,  MIN_VAL,       -32'sd1,       1'b1, MIN_VAL},
    '{ACT_DIV,  32'sd7,        -32'sd2,       1'b1, -32'sd3},
    '{ACT_DIV,  MIN_VAL,       MAX_VAL,       1'b0, 32'sd0},
    '{ACT_REM,  -32'sd7,       32'sd2,        1'b1, -32'sd1},
    '{ACT_REM,  MIN_VAL,       -32'sd1,       1'b1, 32'sd0},
    '{ACT_REM,  MAX_VAL,       -32'sd10,      1'b0, 32'sd0},
    '{ACT_OR,   MIN_VAL,       MAX_VAL,       1'b1, -32'sd1},
    '{ACT_XOR,  -32'sd1,       32'sh5555_5555, 1'b0, 32'sd0},
    '{ACT_AND,  32'shaaaa_aaaa, -32'sd1,      1'b0, 32'sd0},
    '{ACT_CONV, 32'sd10,       32'sd2,        1'b1, 32'sd1010},
    '{ACT_CONV, -32'sd10,      32'sd2,        1'b1, -32'sd1010},
    '{ACT_CONV, 32'sd255,      32'sd16,       1'b1, 32'sd165},
    '{ACT_CONV, 32'sd0,        32'sd7,        1'b1, 32'sd0},
    '{ACT_CONV, MAX_VAL,       32'sd2,        1'b0, 32'sd0},
    '{ACT_CONV, MIN_VAL,       MAX_VAL,       1'b0, 32'sd0},
    '{ACT_CONV, 32'sd5,        MAX_VAL,       1'b1, 32'sd5},
    '{ACT_CONV, MIN_VAL,       32'sd2,        1'b0, 32'sd0}
  };

  function automatic field_t radix_digits(field_t value, field_t radix);
    longint      v;
    longint      r;
    logic [31:0] acc;
    logic [31:0] weight;
    logic [31:0] digit;
    v      = value;
    r      = radix;
    acc    = '0;
    weight = 32'd1;
    while (v != 0) begin
      digit  = 32'(v % r);
      acc    = acc + digit * weight;
      v      = v / r;
      weight = weight * 32'd10;
    end
    return field_t'(acc);
  endfunction

  function automatic alu_result_t alu_outcome(action_t act, field_t a, field_t b);
    alu_result_t o;
    longint      la;
    longint      lb;
    la        = a;
    lb        = b;
    o.result  = '0;
    o.invalid = 1'b0;
    case (act)
      ACT_ADD: o.result = a + b;
      ACT_SUB: o.result = a - b;
      ACT_MUL: o.result = a * b;
      ACT_DIV: begin
        if (b == 0) o.invalid = 1'b1;
        else o.result = field_t'(la / lb);
      end
      ACT_REM: begin
        if (b == 0) o.invalid = 1'b1;
        else o.result = field_t'(la % lb);
      end
      ACT_OR:  o.result = a | b;
      ACT_XOR: o.result = a ^ b;
      ACT_AND: o.result = a & b;
      ACT_CONV: begin
        if (b < RADIX_MIN) o.invalid = 1'b1;
        else o.result = radix_digits(a, b);
      end
      default: o.invalid = 1'b1;
    endcase
    if (o.invalid) o.result = '0;
    return o;
  endfunction

  task automatic flag_error(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : result_check
    alu_result_t want;
    alu_result_t got;
    if (rsp_if.valid && rsp_if.ready) begin
      got.result  = rsp_if.result;
      got.invalid = rsp_if.invalid;
      if (owed_results.size() == 0) begin
        flag_error($sformatf("result %0d invalid %b with none outstanding",
                             got.result, got.invalid));
      end else begin
        want = owed_results.pop_front();
        if (got.result !== want.result)
          flag_error($sformatf("result %0d, predicted %0d", got.result, want.result));
        if (got.invalid !== want.invalid)
          flag_error($sformatf("invalid %b, predicted %b", got.invalid, want.invalid));
      end
    end
    if (req_if.valid && req_if.ready && !alu_halted) begin
      want = alu_outcome(req_if.action, req_if.operand_a, req_if.operand_b);
      if (want.invalid) alu_halted = 1'b1;
      if (row_typed) begin
        want.result  = row_result;
        want.invalid = row_invalid;
      end
      owed_results.push_back(want);
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic offer(action_t act, field_t a, field_t b, bit typed,
                       field_t res, logic inv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.action    <= act;
    req_if.operand_a <= a;
    req_if.operand_b <= b;
    row_typed        <= typed;
    row_result       <= res;
    row_invalid      <= inv;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (owed_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic field_t random_operand();
    case ($urandom_range(0, 5))
      0: return field_t'($urandom_range(0, 40)) - 32'sd20;
      1: begin
        case ($urandom_range(0, 4))
          0: return MIN_VAL;
          1: return MAX_VAL;
          2: return -32'sd1;
          3: return 32'sd0;
          default: return 32'sd1;
        endcase
      end
      2: return field_t'($urandom_range(0, 65535));
      default: return field_t'($urandom);
    endcase
  endfunction

  task automatic offer_random();
    action_t act;
    field_t  a;
    field_t  b;
    act = action_t'($urandom_range(ACT_ADD, ACT_CONV));
    a   = random_operand();
    b   = random_operand();
    case (act)
      ACT_DIV, ACT_REM: begin
        if ($urandom_range(0, 15) == 0) begin
          a = MIN_VAL;
          b = -32'sd1;
        end
        if (b == 0) b = 32'sd1;
      end
      ACT_CONV: begin
        case ($urandom_range(0, 3))
          0: b = field_t'($urandom_range(RADIX_MIN, 16));
          1: b = field_t'($urandom_range(RADIX_MIN, 100));
          2: b = field_t'($urandom_range(RADIX_MIN, 32'h7fff_ffff));
          default: b = 32'sd10;
        endcase
      end
      default: ;
    endcase
    offer(act, a, b, 1'b0, '0, 1'b0);
  endtask

  task automatic offer_rejected();
    reject_e kind;
    action_t act;
    field_t  b;
    kind = reject_e'($urandom_range(REJ_DIV_ZERO, REJ_UNUSED));
    b    = 32'sd0;
    case (kind)
      REJ_DIV_ZERO: act = ACT_DIV;
      REJ_REM_ZERO: act = ACT_REM;
      REJ_LOW_RADIX: begin
        act = ACT_CONV;
        case ($urandom_range(0, 2))
          0: b = 32'sd1;
          1: b = 32'sd0;
          default: b = {1'b1, 31'($urandom)};
        endcase
      end
      REJ_INVALID: act = ACT_INVALID;
      default: act = action_t'(ACT_INVALID) + action_t'($urandom_range(1, 6));
    endcase
    offer(act, random_operand(), b, 1'b1, 32'sd0, 1'b1);
  endtask

  initial begin : stimulus
    int send_pct[3];
    int recv_pct[3];
    send_pct = '{14, 72, 0};
    recv_pct = '{72, 14, 0};
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.action    <= ACT_ADD;
    req_if.operand_a <= '0;
    req_if.operand_b <= '0;
    row_typed        <= 1'b0;
    row_result       <= '0;
    row_invalid      <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].act, directed_rows[i].a, directed_rows[i].b,
            directed_rows[i].typed, directed_rows[i].result, 1'b0);
    end
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      for (int i = 0; i < RANDOM_PER_PH; i++) begin
        if (i == 40 && ph != 1) hold_req = 1'b1;
        offer_random();
      end
      drain_results();
    end

    offer_rejected();
    for (int i = 0; i < 4; i++) offer_random();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
